// ----- hw/rtl/pta_pkg.sv -----
package pta_pkg;

	// request word, one per accepted item
	typedef struct packed {
		logic [1:0]  req_type;
		logic [47:0] src_mac;
		logic [7:0]  peer_caps;
		logic [31:0] peer_height;
		logic [31:0] now_sec;
		logic [2:0]  entry_index;
	} req_t;

	// response word, one per accepted item
	typedef struct packed {
		logic [2:0]  slot;
		logic        slot_valid;
		logic        was_new;
		logic        evicted;
		logic [3:0]  peer_count;
		logic [3:0]  pruned_count;
		logic        hello_due;
		logic [47:0] rd_mac;
		logic [7:0]  rd_caps;
		logic [31:0] rd_height;
		logic [31:0] rd_last_seen;
	} rsp_t;

	// request codes
	localparam logic [1:0] REQ_HELLO = 2'd0;
	localparam logic [1:0] REQ_OTHER = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	// register reset values
	localparam logic [31:0] PEER_TIMEOUT_RST   = 32'd120;
	localparam logic [31:0] HELLO_INTERVAL_RST = 32'd30;

	// one table entry
	typedef struct packed {
		logic [47:0] mac;
		logic [7:0]  caps;
		logic [31:0] height;
		logic [31:0] seen;
	} entry_t;

	// what one cell holds: an entry and its expiry mark from the current tick
	typedef struct packed {
		logic   expired;
		entry_t entry;
	} cell_t;

	// cell load select
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_FWD,
		CELL_BACK
	} cell_op_t;

	// configuration seen by the sequencer
	typedef struct packed {
		logic [31:0] timeout;
		logic [31:0] interval;
	} cfg_t;

	// ring control: rotate and the word fed back into the tail cell
	typedef struct packed {
		logic  shift;
		cell_t tail;
	} ring_ctl_t;

	// stack control: push shifts toward the bottom, pop toward the top
	typedef struct packed {
		cell_op_t op;
		cell_t    push;
	} stack_ctl_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_FINISH
	} state_t;

endpackage

// ----- hw/rtl/pta_cell.sv -----
module pta_cell
	import pta_pkg::*;
(
	input  logic     clk,
	input  cell_op_t op,
	input  cell_t    from_next,
	input  cell_t    from_prev,
	output cell_t    q
);

	cell_t data_q;

	// load from either neighbor or keep
	always_ff @(posedge clk) begin
		case (op)
			CELL_FWD:  data_q <= from_next;
			CELL_BACK: data_q <= from_prev;
			default:   data_q <= data_q;
		endcase
	end

	assign q = data_q;

endmodule

// ----- hw/rtl/pta_stack.sv -----
module pta_stack
	import pta_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  logic       clk,
	input  stack_ctl_t ctl,
	output cell_t      top
);

	cell_t chain [DEPTH];

	// lifo built from a chain of cells, top at cell zero
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		cell_t nxt;
		cell_t prv;

		if (k == DEPTH - 1) begin : g_bottom
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = chain[k + 1];
		end

		if (k == 0) begin : g_top
			assign prv = ctl.push;
		end else begin : g_below
			assign prv = chain[k - 1];
		end

		pta_cell u_cell (
			.clk       (clk),
			.op        (ctl.op),
			.from_next (nxt),
			.from_prev (prv),
			.q         (chain[k])
		);
	end

	assign top = chain[0];

endmodule

// ----- hw/rtl/pta_ctrl.sv -----
module pta_ctrl
	import pta_pkg::*;
#(
	parameter int MAX_PEERS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  req_t       req_data,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp_data,
	input  cfg_t       cfg,
	input  cell_t      head,
	input  cell_t      stack_top,
	output ring_ctl_t  ring_ctl,
	output stack_ctl_t stack_ctl
);

	localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
	localparam int CW = $clog2(MAX_PEERS + 1);
	localparam logic [IW-1:0] LAST_STEP = IW'(MAX_PEERS - 1);
	localparam logic [CW-1:0] FULL      = CW'(MAX_PEERS);

	state_t         state_q, state_d;
	logic [IW-1:0]  step_q;
	logic [CW-1:0]  count_q;
	logic [31:0]    last_hello_q;
	logic           rsp_valid_q;
	rsp_t           rsp_q;

	req_t           req_q;
	logic           found_q;
	logic [IW-1:0]  hit_q;
	logic [IW-1:0]  old_q;
	logic [31:0]    old_seen_q;
	logic [CW-1:0]  keep_q;
	entry_t         rd_q;

	logic           accept;
	logic           finish;
	logic           last;
	logic           live;
	logic           mac_hit;
	logic [31:0]    age;
	logic           expired;
	logic           full;
	logic [IW-1:0]  target;
	logic           rd_match;
	logic           fill;
	logic           due;
	logic [CW-1:0]  count_next;
	entry_t         hello_entry;
	rsp_t           rsp_d;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign finish    = (state_q == ST_FINISH) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// what the head cell tells about the entry passing by
	assign last     = (step_q == LAST_STEP);
	assign live     = (CW'(step_q) < count_q);
	assign mac_hit  = live && (head.entry.mac == req_q.src_mac);
	assign age      = req_q.now_sec - head.entry.seen;
	assign expired  = live && (age > cfg.timeout);
	assign full     = (count_q == FULL);
	assign target   = found_q ? hit_q : (full ? old_q : IW'(count_q));
	assign rd_match = live && (32'(step_q) == 32'(req_q.entry_index));
	assign fill     = (CW'(step_q) < keep_q) && head.expired;
	assign due      = ((req_q.now_sec - last_hello_q) >= cfg.interval);

	// entry written by a hello: refresh of a known peer or a fresh one
	always_comb begin
		if (found_q) begin
			hello_entry.mac    = head.entry.mac;
			hello_entry.caps   = req_q.peer_caps;
			hello_entry.height = (req_q.peer_height != '0) ? req_q.peer_height
				: head.entry.height;
			hello_entry.seen   = req_q.now_sec;
		end else begin
			hello_entry.mac    = req_q.src_mac;
			hello_entry.caps   = req_q.peer_caps;
			hello_entry.height = req_q.peer_height;
			hello_entry.seen   = req_q.now_sec;
		end
	end

	// next state, ring and stack control
	always_comb begin
		state_d        = state_q;
		ring_ctl.shift = 1'b0;
		ring_ctl.tail  = head;
		stack_ctl.op   = CELL_HOLD;
		stack_ctl.push = head;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				ring_ctl.shift = 1'b1;
				if (req_q.req_type == REQ_TICK) begin
					ring_ctl.tail.expired = expired;
					// survivors go on the stack in index order
					if (live && !expired) begin
						stack_ctl.op = CELL_BACK;
					end
				end
				if (last) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				ring_ctl.shift = 1'b1;
				case (req_q.req_type)
					REQ_HELLO: begin
						if (step_q == target) begin
							ring_ctl.tail.entry = hello_entry;
						end
					end
					REQ_OTHER: begin
						if (found_q && step_q == hit_q) begin
							ring_ctl.tail.entry.seen = req_q.now_sec;
						end
					end
					REQ_TICK: begin
						// a hole below the new count takes the highest survivor left
						if (fill) begin
							ring_ctl.tail = stack_top;
							stack_ctl.op  = CELL_FWD;
						end
					end
					default: begin
					end
				endcase
				if (last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// response assembly
	always_comb begin
		rsp_d      = '0;
		count_next = count_q;
		case (req_q.req_type)
			REQ_HELLO: begin
				rsp_d.slot       = 3'(target);
				rsp_d.slot_valid = 1'b1;
				rsp_d.was_new    = !found_q;
				rsp_d.evicted    = !found_q && full;
				if (!found_q && !full) begin
					count_next = count_q + 1'b1;
				end
			end
			REQ_OTHER: begin
				rsp_d.slot       = found_q ? 3'(hit_q) : 3'd0;
				rsp_d.slot_valid = found_q;
			end
			REQ_TICK: begin
				count_next         = keep_q;
				rsp_d.pruned_count = 4'(count_q - keep_q);
				rsp_d.hello_due    = due;
			end
			REQ_READ: begin
				rsp_d.rd_mac       = rd_q.mac;
				rsp_d.rd_caps      = rd_q.caps;
				rsp_d.rd_height    = rd_q.height;
				rsp_d.rd_last_seen = rd_q.seen;
			end
			default: begin
			end
		endcase
		rsp_d.peer_count = 4'(count_next);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			count_q      <= '0;
			last_hello_q <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SCAN || state_q == ST_WRITE) begin
				step_q <= last ? '0 : step_q + 1'b1;
			end
			if (finish) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
				if (req_q.req_type == REQ_TICK && due) begin
					last_hello_q <= req_q.now_sec;
				end
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// scan results and the response word
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req_data;
			found_q <= 1'b0;
			keep_q  <= '0;
			rd_q    <= '0;
		end
		if (state_q == ST_SCAN) begin
			case (req_q.req_type)
				REQ_HELLO, REQ_OTHER: begin
					if (mac_hit && !found_q) begin
						found_q <= 1'b1;
						hit_q   <= step_q;
					end
					// oldest entry, first one wins a tie
					if (step_q == '0 || head.entry.seen < old_seen_q) begin
						old_seen_q <= head.entry.seen;
						old_q      <= step_q;
					end
				end
				REQ_TICK: begin
					if (live && !expired) begin
						keep_q <= keep_q + 1'b1;
					end
				end
				REQ_READ: begin
					if (rd_match) begin
						rd_q <= head.entry;
					end
				end
				default: begin
				end
			endcase
		end
		if (finish) begin
			rsp_q <= rsp_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("live count above table size");

	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SCAN && step_q == '0))
		else $error("scan did not start at the first slot");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_FINISH)
		else $error("response raised outside finish");

	a_tick_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && req_q.req_type == REQ_TICK) |-> keep_q <= count_q)
		else $error("more survivors than live entries");

	a_push_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(stack_ctl.op == CELL_BACK) |-> (state_q == ST_SCAN && req_q.req_type == REQ_TICK))
		else $error("stack push outside tick scan");
`endif

endmodule

// ----- hw/rtl/peer_table_with_aging.sv -----
// Peer table of MAX_PEERS entries (MAC, caps, height, last-seen second) held in a ring of
// cells that rotates by one slot per cycle, while a request is scanned or written back,
// past a head cell where the sequencer looks up, updates, reads and ages entries; a
// second chain of cells works as a stack that carries survivors of a tick back into
// pruned holes. A request is accepted in an idle cycle, then takes one full rotation to
// scan, one more to write back and a finish state that raises the response; the single
// head cell sees one entry per cycle while the ring rotates. One request is in flight at
// a time, so no new one is accepted until the finish state is left; a finished response
// waits in the output register while the next request is accepted, and the finish state
// stalls until that response is taken. Registers: 0x0 peer_timeout, 0x4 hello_interval;
// write them only while no request is in flight; the block itself does not enforce it.
module peer_table_with_aging
	import pta_pkg::*;
#(
	parameter int MAX_PEERS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req_data,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic REG_TIMEOUT  = 1'b0;
	localparam logic REG_INTERVAL = 1'b1;

	logic [31:0] timeout_q;
	logic [31:0] interval_q;
	logic        cfg_wr;
	cfg_t        cfg;
	ring_ctl_t   ring_ctl;
	stack_ctl_t  stack_ctl;
	cell_t       stack_top;
	cell_t       ring [MAX_PEERS];

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= PEER_TIMEOUT_RST;
			interval_q <= HELLO_INTERVAL_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_TIMEOUT:  timeout_q  <= pwdata;
				REG_INTERVAL: interval_q <= pwdata;
				default:      timeout_q  <= timeout_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_TIMEOUT:  prdata = timeout_q;
			REG_INTERVAL: prdata = interval_q;
			default:      prdata = '0;
		endcase
	end

	assign cfg.timeout  = timeout_q;
	assign cfg.interval = interval_q;

	// entry ring, cell zero is the head, the tail is fed by the sequencer
	for (genvar k = 0; k < MAX_PEERS; k++) begin : g_ring
		cell_t nxt;
		cell_t prv;

		if (k == MAX_PEERS - 1) begin : g_tail
			assign nxt = ring_ctl.tail;
		end else begin : g_mid
			assign nxt = ring[k + 1];
		end

		if (k == 0) begin : g_head
			assign prv = ring_ctl.tail;
		end else begin : g_rest
			assign prv = ring[k - 1];
		end

		pta_cell u_cell (
			.clk       (clk),
			.op        (ring_ctl.shift ? CELL_FWD : CELL_HOLD),
			.from_next (nxt),
			.from_prev (prv),
			.q         (ring[k])
		);
	end

	// survivor stack for pruning
	pta_stack #(
		.DEPTH (MAX_PEERS)
	) u_stack (
		.clk (clk),
		.ctl (stack_ctl),
		.top (stack_top)
	);

	// request sequencer
	pta_ctrl #(
		.MAX_PEERS (MAX_PEERS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg       (cfg),
		.head      (ring[0]),
		.stack_top (stack_top),
		.ring_ctl  (ring_ctl),
		.stack_ctl (stack_ctl)
	);

endmodule
